### rtl/dcns_pkg.sv
// ----------------------------------------------------------------------------
// dcns_pkg
// Shared types and fixed constants for the diode clipper Newton solver.
// ----------------------------------------------------------------------------
package dcns_pkg;

  // shared multiplier: 64 x 64 operands, built from 32 x 32 partial products
  localparam int MUL_W  = 64;
  localparam int PROD_W = 2 * MUL_W;

  // configuration port
  localparam int CFG_W = 32;
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_STEP_RC    = 3'd0;
  localparam logic [IDX_W-1:0] REG_DIODE_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_ALPHA      = 3'd2;
  localparam logic [IDX_W-1:0] REG_TOLERANCE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ITER_LIMIT = 3'd4;

  // exp / hyperbolic constants
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam int          HYP_W     = 48;
  localparam logic [HYP_W-1:0] HYP_MAX = '1;
  localparam int          EP_W      = 52;
  localparam logic [EP_W-1:0] EXP_CAP = 52'h4_0000_0000_0000;
  localparam logic [3:0]  TAYLOR_TERMS = 4'd12;

  // multiply phases
  localparam logic [2:0] PH_LL = 3'd0;
  localparam logic [2:0] PH_LH = 3'd1;
  localparam logic [2:0] PH_HL = 3'd2;
  localparam logic [2:0] PH_HH = 3'd3;
  localparam logic [2:0] PH_LAST = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KA,
    ST_X,
    ST_Y,
    ST_T,
    ST_TERM,
    ST_DIVK,
    ST_EN,
    ST_DMAG,
    ST_RMAG,
    ST_CT,
    ST_Q,
    ST_UPD,
    ST_DONE
  } state_t;

endpackage

### rtl/dcns_mul.sv
// ----------------------------------------------------------------------------
// dcns_mul
// Multi-cycle 64 x 64 unsigned multiplier over one 32 x 32 partial product.
// ----------------------------------------------------------------------------
module dcns_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dcns_pkg::MUL_W-1:0]   a,
  input  logic [dcns_pkg::MUL_W-1:0]   b,
  output logic [dcns_pkg::PROD_W-1:0]  product,
  output logic                         done
);

  localparam int HW = dcns_pkg::MUL_W / 2;

  logic [dcns_pkg::MUL_W-1:0] a_r, b_r, pp;
  logic [2:0]                 phase;
  logic                       busy;
  logic [HW-1:0]              ma, mb;

  always_comb begin
    case (phase)
      dcns_pkg::PH_LL: begin
        ma = a_r[HW-1:0];
        mb = b_r[HW-1:0];
      end
      dcns_pkg::PH_LH: begin
        ma = a_r[HW-1:0];
        mb = b_r[dcns_pkg::MUL_W-1:HW];
      end
      dcns_pkg::PH_HL: begin
        ma = a_r[dcns_pkg::MUL_W-1:HW];
        mb = b_r[HW-1:0];
      end
      default: begin
        ma = a_r[dcns_pkg::MUL_W-1:HW];
        mb = b_r[dcns_pkg::MUL_W-1:HW];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r     <= a;
        b_r     <= b;
        product <= '0;
        phase   <= dcns_pkg::PH_LL;
        busy    <= 1'b1;
      end else if (busy) begin
        pp    <= ma * mb;
        phase <= phase + 3'd1;
        case (phase) inside
          dcns_pkg::PH_LH: product <= product + dcns_pkg::PROD_W'(pp);
          dcns_pkg::PH_HL, dcns_pkg::PH_HH:
            product <= product + (dcns_pkg::PROD_W'(pp) << HW);
          dcns_pkg::PH_LAST: begin
            product <= product + (dcns_pkg::PROD_W'(pp) << dcns_pkg::MUL_W);
            busy    <= 1'b0;
            done    <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

### rtl/dcns_div.sv
// ----------------------------------------------------------------------------
// dcns_div
// Restoring divider, one quotient bit per cycle, aligned dividend.
// ----------------------------------------------------------------------------
module dcns_div #(
  parameter int DVW = 70,
  parameter int DSW = 55,
  parameter int QW  = 40,
  parameter int CW  = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [CW-1:0]  steps,
  input  logic [DSW-1:0] divisor,
  output logic [QW-1:0]  quotient,
  output logic           done
);

  logic [DSW-1:0] rem, dsr;
  logic [DVW-1:0] dvd;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic [DSW:0]   rs, rs_sub;
  logic           ge;

  // remainder stays below the divisor, so one bit more covers the shift
  assign rs     = {rem, dvd[DVW-1]};
  assign ge     = rs >= {1'b0, dsr};
  assign rs_sub = rs - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= steps;
        rem      <= '0;
        dvd      <= dividend;
        dsr      <= divisor;
        quotient <= '0;
      end else if (busy) begin
        rem      <= ge ? rs_sub[DSW-1:0] : rs[DSW-1:0];
        dvd      <= {dvd[DVW-2:0], 1'b0};
        quotient <= {quotient[QW-2:0], ge};
        cnt      <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/diode_clipper_newton_solver.sv
// ----------------------------------------------------------------------------
// diode_clipper_newton_solver
// RC diode clipper, backward Euler, Newton iteration on a shared mul/div pair.
// ----------------------------------------------------------------------------
//
//   channel   signals                                        handshake
//   -------   --------------------------------------------   ------------
//   input     sample_in, block_end                           in_valid/in_ready
//   output    sample_out, converged, block_end_out           out_valid/out_ready
//   config    reg_index, write_data                          write_enable
//
// Steps: an item forms the kd*a product once, then each Newton iteration runs
//   the multiplies, twelve Taylor terms each with a divide by k, a divide for
//   e^-x (the exponential steps are skipped when a*|v| saturates) and a
//   Newton divide. The iteration count is set by convergence, capped at
//   iteration_limit.
// Reset: synchronous; config registers take their defaults, stored voltage 0.
// Stalls: in_ready is high only while idle. A finished item waits in the
//   output register; the next item is accepted meanwhile, and only its own
//   completion waits for the output register to drain.
//
module diode_clipper_newton_solver #(
  parameter int SAMPLE_WIDTH   = 24,
  parameter int VOLT_FRAC_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in,
  input  logic                              block_end,
  // output channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    sample_out,
  output logic                              converged,
  output logic                              block_end_out,
  // config port
  input  logic                              write_enable,
  input  logic [dcns_pkg::IDX_W-1:0]        reg_index,
  input  logic [dcns_pkg::CFG_W-1:0]        write_data
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int VF   = VOLT_FRAC_BITS;
  localparam int DMW  = 16 + VF;             // diode term magnitude
  localparam int RMW  = SW + 2;              // rc term magnitude
  localparam int GW   = ((SW + 3 > DMW + 1) ? SW + 3 : DMW + 1) + 3;  // g, v-g
  localparam int DVW  = GW + 30;             // Newton dividend |v-g| << 30
  localparam int QW   = (GW > 33) ? GW : 33;
  localparam int DSW  = 55;                  // denominator width
  localparam int CW   = $clog2(DVW + 1);
  localparam int KA_W = 56;
  localparam int CT_W = 54;
  localparam int MW   = dcns_pkg::MUL_W;
  localparam int PW   = dcns_pkg::PROD_W;
  localparam int EW   = dcns_pkg::EP_W;

  localparam logic signed [GW+1:0] VMAX = {{(GW+3-SW){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [GW+1:0] VMIN = ~VMAX;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] step_rc_coeff;
  logic [31:0] diode_gain_coeff;
  logic [23:0] diode_alpha;
  logic [15:0] tolerance;
  logic [7:0]  iteration_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_rc_coeff    <= 32'd243480000;
      diode_gain_coeff <= 32'd321700000;
      diode_alpha      <= 24'd1424700;
      tolerance        <= 16'd105;
      iteration_limit  <= 8'd250;
    end else if (write_enable) begin
      unique case (reg_index)
        dcns_pkg::REG_STEP_RC:    step_rc_coeff    <= write_data;
        dcns_pkg::REG_DIODE_GAIN: diode_gain_coeff <= write_data;
        dcns_pkg::REG_ALPHA:      diode_alpha      <= write_data[23:0];
        dcns_pkg::REG_TOLERANCE:  tolerance        <= write_data[15:0];
        dcns_pkg::REG_ITER_LIMIT: iteration_limit  <= write_data[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // shared units
  // --------------------------------------------------------------------------
  logic           mul_start, mul_done;
  logic [MW-1:0]  mul_a, mul_b;
  logic [PW-1:0]  mul_p;

  logic           div_start, div_done;
  logic [DVW-1:0] div_dvd;
  logic [CW-1:0]  div_steps;
  logic [DSW-1:0] div_dsr;
  logic [QW-1:0]  div_q;

  dcns_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_p),
    .done    (mul_done)
  );

  dcns_div #(
    .DVW (DVW),
    .DSW (DSW),
    .QW  (QW),
    .CW  (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .steps    (div_steps),
    .divisor  (div_dsr),
    .quotient (div_q),
    .done     (div_done)
  );

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  dcns_pkg::state_t state, state_next;
  logic                 issued;
  logic signed [SW-1:0] vin, v, last_v;
  logic                 be_r, conv;
  logic [7:0]           it;
  logic [KA_W-1:0]      ka;          // kd * a, once per item
  logic [29:0]          xq;          // a*|v| in Q.24
  logic [6:0]           n_int;       // integer part of x*log2e
  logic [23:0]          f_frac;      // fraction of x*log2e
  logic [29:0]          t_ln;        // f*ln2, Q.30
  logic [30:0]          term;
  logic [31:0]          sum;
  logic [3:0]           k;
  logic [dcns_pkg::HYP_W-1:0] sh_v, ch_v;
  logic [DMW-1:0]       dmag;
  logic [RMW-1:0]       rmag;
  logic [CT_W-1:0]      ct;
  logic [QW-1:0]        quo;

  // --------------------------------------------------------------------------
  // combinational helpers
  // --------------------------------------------------------------------------
  logic [SW-1:0]           vm;
  logic signed [SW:0]      diff;
  logic [SW:0]             diff_mag;
  logic [PW-1:0]           xw, dw;
  logic                    xsat;
  logic [EW-1:0]           p_ext, ep_shl, ep, en_ext, s_w, c_w;
  logic [dcns_pkg::HYP_W-1:0] s_sat, c_sat;
  logic signed [GW-1:0]    rc_s, ds_s, g, num;
  logic [GW-1:0]           nmag;
  logic [DSW-1:0]          den;
  logic signed [GW+1:0]    q_s, vn;
  logic signed [SW-1:0]    vn_sat;
  logic signed [SW:0]      dd;
  logic [SW:0]             dd_mag;
  logic                    step_ok;
  logic [8:0]              it_inc;
  logic                    more;

  assign vm       = v[SW-1] ? SW'(-v) : SW'(v);
  assign diff     = (SW+1)'(vin) - (SW+1)'(v);
  assign diff_mag = diff[SW] ? (SW+1)'(-diff) : (SW+1)'(diff);

  // a*|v| down to Q.24; beyond 64 the hyperbolics saturate
  assign xw   = mul_p >> (VF - 8);
  assign xsat = |xw[PW-1:30];
  assign dw   = mul_p >> (64 - VF);

  // e^x in Q.16 from 2^frac (Q.30) and the integer exponent
  always_comb begin
    p_ext  = EW'(sum);
    ep_shl = '0;
    if (n_int >= 7'd14) begin
      if (n_int - 7'd14 >= 7'd20) begin
        ep = dcns_pkg::EXP_CAP;
      end else begin
        ep_shl = p_ext << (n_int - 7'd14);
        ep     = (ep_shl > dcns_pkg::EXP_CAP) ? dcns_pkg::EXP_CAP : ep_shl;
      end
    end else begin
      ep = p_ext >> (7'd14 - n_int);
    end
    if (ep == '0) ep = EW'(1);
  end

  assign en_ext = EW'(div_q[32:0]);
  assign s_w    = (ep - en_ext) >> 1;
  assign c_w    = (ep + en_ext) >> 1;
  assign s_sat  = (s_w > EW'(dcns_pkg::HYP_MAX)) ? dcns_pkg::HYP_MAX
                                                 : s_w[dcns_pkg::HYP_W-1:0];
  assign c_sat  = (c_w > EW'(dcns_pkg::HYP_MAX)) ? dcns_pkg::HYP_MAX
                                                 : c_w[dcns_pkg::HYP_W-1:0];

  // g = last + krc*(vin-v) - kd*sinh(a*v), signs applied to magnitudes
  always_comb begin
    rc_s = GW'($signed({1'b0, rmag}));
    if (diff[SW]) rc_s = -rc_s;
    ds_s = GW'($signed({1'b0, dmag}));
    if (v[SW-1]) ds_s = -ds_s;
  end

  assign g    = GW'(last_v) + rc_s - ds_s;
  assign num  = GW'(v) - g;
  assign nmag = num[GW-1] ? GW'(-num) : GW'(num);
  assign den  = DSW'(34'h4000_0000) + DSW'(step_rc_coeff) + DSW'(ct);

  // Newton update, clamped to the sample range
  assign q_s = $signed({2'b00, quo[GW-1:0]});
  assign vn  = num[GW-1] ? ((GW+2)'(v) + q_s) : ((GW+2)'(v) - q_s);

  always_comb begin
    if (vn > VMAX)      vn_sat = VMAX[SW-1:0];
    else if (vn < VMIN) vn_sat = VMIN[SW-1:0];
    else                vn_sat = vn[SW-1:0];
  end

  assign dd      = (SW+1)'(vn_sat) - (SW+1)'(v);
  assign dd_mag  = dd[SW] ? (SW+1)'(-dd) : (SW+1)'(dd);
  assign step_ok = dd_mag <= (SW+1)'(tolerance);
  assign it_inc  = 9'(it) + 9'd1;
  assign more    = it_inc < 9'(iteration_limit);

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      dcns_pkg::ST_IDLE:
        if (in_valid)
          state_next = (iteration_limit == 8'd0) ? dcns_pkg::ST_DONE : dcns_pkg::ST_KA;
      dcns_pkg::ST_KA:   if (mul_done) state_next = dcns_pkg::ST_X;
      dcns_pkg::ST_X:
        if (mul_done) state_next = xsat ? dcns_pkg::ST_DMAG : dcns_pkg::ST_Y;
      dcns_pkg::ST_Y:    if (mul_done) state_next = dcns_pkg::ST_T;
      dcns_pkg::ST_T:    if (mul_done) state_next = dcns_pkg::ST_TERM;
      dcns_pkg::ST_TERM: if (mul_done) state_next = dcns_pkg::ST_DIVK;
      dcns_pkg::ST_DIVK:
        if (div_done)
          state_next = (k == dcns_pkg::TAYLOR_TERMS) ? dcns_pkg::ST_EN : dcns_pkg::ST_TERM;
      dcns_pkg::ST_EN:   if (div_done) state_next = dcns_pkg::ST_DMAG;
      dcns_pkg::ST_DMAG: if (mul_done) state_next = dcns_pkg::ST_RMAG;
      dcns_pkg::ST_RMAG: if (mul_done) state_next = dcns_pkg::ST_CT;
      dcns_pkg::ST_CT:   if (mul_done) state_next = dcns_pkg::ST_Q;
      dcns_pkg::ST_Q:    if (div_done) state_next = dcns_pkg::ST_UPD;
      dcns_pkg::ST_UPD:
        state_next = (step_ok || !more) ? dcns_pkg::ST_DONE : dcns_pkg::ST_X;
      dcns_pkg::ST_DONE:
        if (!out_valid || out_ready) state_next = dcns_pkg::ST_IDLE;
      default: state_next = dcns_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: unit control and operand select
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_dvd   = '0;
    div_steps = '0;
    div_dsr   = '0;
    unique case (state)
      dcns_pkg::ST_IDLE: in_ready = 1'b1;
      dcns_pkg::ST_KA: begin
        mul_start = !issued;
        mul_a     = MW'(diode_gain_coeff);
        mul_b     = MW'(diode_alpha);
      end
      dcns_pkg::ST_X: begin
        mul_start = !issued;
        mul_a     = MW'(diode_alpha);
        mul_b     = MW'(vm);
      end
      dcns_pkg::ST_Y: begin
        mul_start = !issued;
        mul_a     = MW'(xq);
        mul_b     = MW'(dcns_pkg::LOG2E_Q30);
      end
      dcns_pkg::ST_T: begin
        mul_start = !issued;
        mul_a     = MW'(f_frac);
        mul_b     = MW'(dcns_pkg::LN2_Q30);
      end
      dcns_pkg::ST_TERM: begin
        mul_start = !issued;
        mul_a     = MW'(term);
        mul_b     = MW'(t_ln);
      end
      dcns_pkg::ST_DIVK: begin
        div_start = !issued;
        div_dvd   = {term[29:0], {(DVW-30){1'b0}}};
        div_steps = CW'(30);
        div_dsr   = DSW'(k);
      end
      dcns_pkg::ST_EN: begin
        // 2^32 / e^x
        div_start = !issued;
        div_dvd   = {1'b1, {(DVW-1){1'b0}}};
        div_steps = CW'(33);
        div_dsr   = DSW'(ep);
      end
      dcns_pkg::ST_DMAG: begin
        mul_start = !issued;
        mul_a     = MW'(diode_gain_coeff);
        mul_b     = MW'(sh_v);
      end
      dcns_pkg::ST_RMAG: begin
        mul_start = !issued;
        mul_a     = MW'(step_rc_coeff);
        mul_b     = MW'(diff_mag);
      end
      dcns_pkg::ST_CT: begin
        mul_start = !issued;
        mul_a     = MW'(ka);
        mul_b     = MW'(ch_v);
      end
      dcns_pkg::ST_Q: begin
        div_start = !issued;
        div_dvd   = {nmag, 30'd0};
        div_steps = CW'(DVW);
        div_dsr   = den;
      end
      dcns_pkg::ST_UPD: ;
      dcns_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // state, datapath and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dcns_pkg::ST_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      last_v    <= '0;
    end else begin
      state <= state_next;

      if (mul_start || div_start) issued <= 1'b1;
      else if (mul_done || div_done) issued <= 1'b0;

      // a new result reloads the output register in ST_DONE instead
      if (out_valid && out_ready && state != dcns_pkg::ST_DONE) out_valid <= 1'b0;

      unique case (state)
        dcns_pkg::ST_IDLE:
          if (in_valid) begin
            vin  <= sample_in;
            be_r <= block_end;
            v    <= last_v;
            it   <= '0;
            conv <= 1'b0;
          end
        dcns_pkg::ST_KA: if (mul_done) ka <= mul_p[KA_W-1:0];
        dcns_pkg::ST_X:
          if (mul_done) begin
            if (xsat) begin
              sh_v <= dcns_pkg::HYP_MAX;
              ch_v <= dcns_pkg::HYP_MAX;
            end else begin
              xq <= xw[29:0];
            end
          end
        dcns_pkg::ST_Y:
          if (mul_done) begin
            n_int  <= mul_p[60:54];
            f_frac <= mul_p[53:30];
          end
        dcns_pkg::ST_T:
          if (mul_done) begin
            t_ln <= mul_p[53:24];
            term <= 31'h4000_0000;
            sum  <= 32'h4000_0000;
            k    <= 4'd1;
          end
        dcns_pkg::ST_TERM: if (mul_done) term <= {1'b0, mul_p[59:30]};
        dcns_pkg::ST_DIVK:
          if (div_done) begin
            term <= div_q[30:0];
            sum  <= sum + 32'(div_q[30:0]);
            k    <= k + 4'd1;
          end
        dcns_pkg::ST_EN:
          if (div_done) begin
            sh_v <= s_sat;
            ch_v <= c_sat;
          end
        dcns_pkg::ST_DMAG: if (mul_done) dmag <= dw[DMW-1:0];
        dcns_pkg::ST_RMAG: if (mul_done) rmag <= mul_p[30+RMW-1:30];
        dcns_pkg::ST_CT:   if (mul_done) ct <= mul_p[50+CT_W-1:50];
        dcns_pkg::ST_Q:    if (div_done) quo <= div_q;
        dcns_pkg::ST_UPD: begin
          v    <= vn_sat;
          it   <= it_inc[7:0];
          conv <= step_ok;
        end
        dcns_pkg::ST_DONE:
          if (!out_valid || out_ready) begin
            last_v        <= v;
            sample_out    <= v;
            converged     <= conv;
            block_end_out <= be_r;
            out_valid     <= 1'b1;
          end
        default: ;
      endcase
    end
  end

endmodule
